FILE: src/bicubic_catmull_rom_kernel_core_defines.svh
// Assertion macros shared by the bicubic Catmull-Rom kernel RTL.
`ifndef BICUBIC_CATMULL_ROM_KERNEL_CORE_DEFINES_SVH
`define BICUBIC_CATMULL_ROM_KERNEL_CORE_DEFINES_SVH

// consequent must hold on the same edge as the antecedent
`define BCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold on the edge after the antecedent
`define BCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bcr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bicubic Catmull-Rom kernel.
package bcr_pkg;

   // column slot of the fourth item of a group
   localparam logic [1:0] COL_LAST = 2'd3;

   // front-to-back queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // classification attached to every queued item
   typedef struct packed {
      logic [1:0] col_idx;
      logic       last;
   } item_tag_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_COEF   = 8'b0000_0010,
      ST_MUL_A  = 8'b0000_0100,
      ST_ADD_B  = 8'b0000_1000,
      ST_MUL_H2 = 8'b0001_0000,
      ST_ADD_C  = 8'b0010_0000,
      ST_MUL_H3 = 8'b0100_0000,
      ST_ROUND  = 8'b1000_0000
   } back_state_type;

endpackage

FILE: src/bcr_front.sv
`timescale 1ns / 1ps
// Front end: takes input transfers and tags each with its column slot.
module bcr_front import bcr_pkg::*; #(
   parameter int DATA_WIDTH = 96
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_data,
   input  logic                  q_full,
   output logic                  push,
   output logic [DATA_WIDTH-1:0] push_data,
   output item_tag_type          push_tag
);

   logic [1:0] col_cnt_ff;
   logic [1:0] col_cnt_in;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;
   assign push_data  = req_data;

   always_comb begin
      push_tag.col_idx = col_cnt_ff;
      push_tag.last    = (col_cnt_ff == COL_LAST);
   end

   // counter wraps after the fourth column
   assign col_cnt_in = push ? 2'(col_cnt_ff + 2'd1) : col_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
      end
   end

endmodule

FILE: src/bcr_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the arithmetic back end.
module bcr_queue import bcr_pkg::*; #(
   parameter int WIDTH = 99
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

`include "bicubic_catmull_rom_kernel_core_defines.svh"

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BCR_ASSERT_SAME(a_no_push_full, clock, reset, push, count_ff != CNT_W'(QUEUE_DEPTH), "push into full queue")
   `BCR_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == CNT_W'($past(count_ff) + 1'b1), "queue count did not grow on push")

endmodule

FILE: src/bcr_back.sv
`timescale 1ns / 1ps
// Back end: Horner evaluation on one shared multiplier, column store, result register.
module bcr_back import bcr_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_WIDTH   = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      q_valid,
   input  logic [4*SAMPLE_WIDTH+2*FRAC_WIDTH-1:0]    q_data,
   input  item_tag_type                              q_tag,
   output logic                                      q_pop,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]                   rsp_value,
   output logic                                      rsp_saturated
);

`include "bicubic_catmull_rom_kernel_core_defines.svh"

   localparam int SW = SAMPLE_WIDTH;
   localparam int FW = FRAC_WIDTH;
   localparam int CW = SW + 2;          // column value width
   localparam int HW = SW + 7;          // coefficient and Horner width
   localparam int PW = FW + 1 + HW;     // product width

   localparam logic signed [PW-1:0] HALF_F = PW'(1) << (FW - 1);
   localparam logic signed [PW-1:0] HALF_R = PW'(1) << FW;
   localparam logic [CW-1:0] COL_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] COL_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};

   back_state_type state_ff, state_in;
   logic signed [CW-1:0] p_ff [4];
   logic signed [CW-1:0] p_in [4];
   logic signed [CW-1:0] col_ff [3];
   logic signed [CW-1:0] col_in [3];
   logic [FW-1:0]        t_ff, t_in;
   logic [FW-1:0]        fx_ff, fx_in;
   item_tag_type         tag_ff, tag_in;
   logic                 pass2_ff, pass2_in;
   logic signed [HW-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, h_ff, h_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]        rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic signed [HW-1:0] pe [4];
   logic signed [CW-1:0] q_smp [4];
   logic signed [HW-1:0] d12, coef_a, coef_b, coef_c, mul_opd;
   logic signed [PW-1:0] mul_res, sum_f, sum_r, shf_f, shf_r;
   logic signed [HW-1:0] rnd_f, rnd_r, f_val;
   logic [HW-CW:0]       col_hi;
   logic [HW-SW:0]       res_hi;
   logic                 col_ovf, res_ovf, out_free, rsp_load;
   logic [CW-1:0]        col_clamped;
   logic [SW-1:0]        res_clamped;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pe[i]    = {{(HW-CW){p_ff[i][CW-1]}}, p_ff[i]};
         q_smp[i] = {{2{q_data[i*SW+SW-1]}}, q_data[i*SW +: SW]};
      end
   end

   // Catmull-Rom coefficients
   assign d12    = pe[1] - pe[2];
   assign coef_a = (d12 <<< 1) + d12 + pe[3] - pe[0];
   assign coef_b = (pe[0] <<< 1) - (pe[1] <<< 2) - pe[1] + (pe[2] <<< 2) - pe[3];
   assign coef_c = pe[2] - pe[0];

   // shared multiplier
   assign mul_opd = (state_ff == ST_MUL_A) ? a_ff : h_ff;
   assign mul_res = $signed({1'b0, t_ff}) * mul_opd;

   // round half up after the shift
   assign sum_f = prod_ff + HALF_F;
   assign sum_r = prod_ff + HALF_R;
   assign shf_f = sum_f >>> FW;
   assign shf_r = sum_r >>> (FW + 1);
   assign rnd_f = shf_f[HW-1:0];
   assign rnd_r = shf_r[HW-1:0];
   assign f_val = pe[1] + rnd_r;

   // saturation to column width and to sample width
   assign col_hi      = f_val[HW-1:CW-1];
   assign col_ovf     = !((&col_hi) || !(|col_hi));
   assign col_clamped = col_ovf ? (f_val[HW-1] ? COL_MIN : COL_MAX) : f_val[CW-1:0];
   assign res_hi      = f_val[HW-1:SW-1];
   assign res_ovf     = !((&res_hi) || !(|res_hi));
   assign res_clamped = res_ovf ? (f_val[HW-1] ? SMP_MIN : SMP_MAX) : f_val[SW-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == ST_ROUND) && pass2_ff && out_free;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      col_in       = col_ff;
      t_in         = t_ff;
      fx_in        = fx_ff;
      tag_in       = tag_ff;
      pass2_in     = pass2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      h_in         = h_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               p_in     = q_smp;
               t_in     = q_data[4*SW +: FW];
               fx_in    = q_data[4*SW+FW +: FW];
               tag_in   = q_tag;
               pass2_in = 1'b0;
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            a_in     = coef_a;
            b_in     = coef_b;
            c_in     = coef_c;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            prod_in  = mul_res;
            state_in = ST_ADD_B;
         end
         ST_ADD_B: begin
            h_in     = b_ff + rnd_f;
            state_in = ST_MUL_H2;
         end
         ST_MUL_H2: begin
            prod_in  = mul_res;
            state_in = ST_ADD_C;
         end
         ST_ADD_C: begin
            h_in     = c_ff + rnd_f;
            state_in = ST_MUL_H3;
         end
         ST_MUL_H3: begin
            prod_in  = mul_res;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (pass2_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = res_clamped;
                  rsp_sat_in   = res_ovf;
                  state_in     = ST_IDLE;
               end
            end else if (tag_ff.last) begin
               // fourth column: run the cubic across the stored columns
               p_in[0]  = col_ff[0];
               p_in[1]  = col_ff[1];
               p_in[2]  = col_ff[2];
               p_in[3]  = col_clamped;
               t_in     = fx_ff;
               pass2_in = 1'b1;
               state_in = ST_COEF;
            end else begin
               col_in[tag_ff.col_idx] = col_clamped;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      col_ff       <= col_in;
      t_ff         <= t_in;
      fx_ff        <= fx_in;
      tag_ff       <= tag_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      h_ff         <= h_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;

   `BCR_ASSERT_NEXT(a_second_pass, clock, reset, state_ff == ST_ROUND && !pass2_ff && tag_ff.last, state_ff == ST_COEF && pass2_ff, "fourth column did not start the row pass")
   `BCR_ASSERT_SAME(a_load_source, clock, reset, rsp_load, pass2_ff && tag_ff.last, "result loaded outside the row pass of a fourth column")

endmodule

FILE: src/bicubic_catmull_rom_kernel_core.sv
`timescale 1ns / 1ps
// Top level of the bicubic Catmull-Rom kernel: front end, item queue, arithmetic back end.
// Back end runs each cubic through COEF, MUL_A, ADD_B, MUL_H2, ADD_C, MUL_H3 and ROUND states
// on one shared multiplier (3 multiplies); the fourth item runs a second cubic across the columns.
// The back end takes one item at a time; the 2-entry queue absorbs input bursts.
// Reset (synchronous, high) empties the queue, zeroes the column counter, drops rsp_tvalid.
module bicubic_catmull_rom_kernel_core import bcr_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_WIDTH   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // input column
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample_0, sample_1, sample_2, sample_3, frac_y, frac_x; zero padded to bytes
   input  logic [((4*SAMPLE_WIDTH+2*FRAC_WIDTH+7)/8)*8-1:0] req_tdata,
   // result
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // value; zero padded to bytes
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic                     rsp_tuser
);

   localparam int DATA_WIDTH = 4*SAMPLE_WIDTH + 2*FRAC_WIDTH;
   localparam int OUT_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int TAG_WIDTH  = $bits(item_tag_type);
   localparam int QW         = DATA_WIDTH + TAG_WIDTH;

   logic                    push, q_full, q_pop, q_valid;
   logic [DATA_WIDTH-1:0]   push_data;
   item_tag_type            push_tag, q_tag;
   logic [QW-1:0]           q_out;
   logic [SAMPLE_WIDTH-1:0] value;

   // front end: handshake and column-slot tagging
   bcr_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata[DATA_WIDTH-1:0]),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data),
      .push_tag   (push_tag)
   );

   // decouples input transfers from the multi-cycle arithmetic
   bcr_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_tag, push_data}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .not_empty (q_valid)
   );

   assign q_tag = item_tag_type'(q_out[QW-1:DATA_WIDTH]);

   // back end: column cubic at frac_y, then row cubic at frac_x on the fourth item
   bcr_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_WIDTH   (FRAC_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_out[DATA_WIDTH-1:0]),
      .q_tag         (q_tag),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_value     (value),
      .rsp_saturated (rsp_tuser)
   );

   assign rsp_tdata = OUT_WIDTH'(value);

endmodule

FILE: test/bicubic_catmull_rom_kernel_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the bicubic kernel: column stream in, checked pixel results out.
module bicubic_catmull_rom_kernel_core_tb;

   // Expected-pixel tracker: mirrors the column store and predicts each group's pixel.
   class pixel_scoreboard;
      localparam int SAMPLE_W = 16;
      localparam int FRAC_W   = 16;
      localparam int COLUMN_W = SAMPLE_W + 2;

      typedef struct packed {
         logic [SAMPLE_W-1:0] value;
         logic                saturated;
      } pixel_type;

      logic [1:0] columns_seen;
      longint     stored_columns[3];
      pixel_type  pending_pixels[$];
      int         errors;

      function new();
         columns_seen = 2'd0;
         foreach (stored_columns[i]) stored_columns[i] = 0;
         errors = 0;
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction

      // round half up: floor((v + 2^(s-1)) / 2^s)
      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint saturate(longint v, int w, output logic hit);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         hit = 1'b0;
         if (v > hi) begin
            hit = 1'b1;
            return hi;
         end
         if (v < lo) begin
            hit = 1'b1;
            return lo;
         end
         return v;
      endfunction

      // Catmull-Rom cubic in Horner form, t is Q0.FRAC_W
      function longint cubic(longint p0, longint p1, longint p2, longint p3, longint t);
         longint a;
         longint b;
         longint c;
         longint h2;
         longint h3;
         a  = 3 * (p1 - p2) + p3 - p0;
         b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         c  = p2 - p0;
         h2 = b + round_shift(t * a, FRAC_W);
         h3 = c + round_shift(t * h2, FRAC_W);
         return p1 + round_shift(t * h3, FRAC_W + 1);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t: MISMATCH %s", $time, what);
      endtask

      // one accepted column transfer
      function void note_column(logic [95:0] d);
         longint    p[4];
         longint    frac_y;
         longint    frac_x;
         longint    col;
         longint    pix;
         logic      col_hit;
         logic      pix_hit;
         pixel_type want;
         for (int i = 0; i < 4; i++) p[i] = longint'($signed(d[16*i +: 16]));
         frac_y = longint'(d[79:64]);
         frac_x = longint'(d[95:80]);
         // column clamp never flags the result
         col = saturate(cubic(p[0], p[1], p[2], p[3], frac_y), COLUMN_W, col_hit);
         if (columns_seen != 2'd3) begin
            stored_columns[columns_seen] = col;
            columns_seen++;
         end else begin
            pix = saturate(cubic(stored_columns[0], stored_columns[1], stored_columns[2],
                                 col, frac_x), SAMPLE_W, pix_hit);
            want.value     = pix[SAMPLE_W-1:0];
            want.saturated = pix_hit;
            pending_pixels.push_back(want);
            columns_seen = 2'd0;
         end
      endfunction

      // one accepted result transfer
      task check_result(logic [15:0] value, logic saturated);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel value %0d sat %b",
                                      $signed(value), saturated));
            return;
         end
         want = pending_pixels.pop_front();
         if (value !== want.value || saturated !== want.saturated)
            report_mismatch($sformatf("pixel got value %0d sat %b, want value %0d sat %b",
                                      $signed(value), saturated,
                                      $signed(want.value), want.saturated));
      endtask
   endclass

   typedef enum int {MIX_RANDOM, MIX_SMOOTH, MIX_EXTREME} column_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // sample_0, sample_1, sample_2, sample_3, frac_y, frac_x
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // value
   logic        rsp_tuser;        // saturated

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   pixel_scoreboard pixels;

   bicubic_catmull_rom_kernel_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random stalls, check every completed transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) pixels.check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic logic [95:0] pack_column(logic [15:0] s0, logic [15:0] s1,
                                               logic [15:0] s2, logic [15:0] s3,
                                               logic [15:0] fy, logic [15:0] fx);
      return {fx, fy, s3, s2, s1, s0};
   endfunction

   // valid is only lowered for a gap, so it is never dropped and raised in one step
   task automatic send_column(logic [95:0] d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pixels.note_column(d);
   endtask

   // hold input off until every pixel owed has come out
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pixels.outstanding() != 0);
   endtask

   function automatic logic [15:0] pick_frac();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_sample(column_mix_type mix, logic [15:0] base);
      case (mix)
         MIX_SMOOTH: return base + 16'($urandom_range(0, 512)) - 16'd256;
         MIX_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       return 16'h8000;
               1:       return 16'h7fff;
               default: return 16'($urandom);
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_group();
      column_mix_type mix;
      logic [15:0]    base;
      logic [15:0]    s[4];
      mix  = column_mix_type'($urandom_range(0, 2));
      base = 16'($urandom);
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) s[i] = pick_sample(mix, base);
         send_column(pack_column(s[0], s[1], s[2], s[3], pick_frac(), pick_frac()));
      end
   endtask

   task automatic send_directed();
      // all zero
      for (int c = 0; c < 4; c++)
         send_column(pack_column(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      // flat maximum, fractions at their top
      for (int c = 0; c < 4; c++)
         send_column(pack_column(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff));
      // flat minimum
      for (int c = 0; c < 4; c++)
         send_column(pack_column(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000));
      // overshoot above range; frac_x of the first three columns must not matter
      for (int c = 0; c < 4; c++)
         send_column(pack_column(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                                 (c == 3) ? 16'h1234 : 16'($urandom)));
      // overshoot below range
      for (int c = 0; c < 4; c++)
         send_column(pack_column(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                 (c == 3) ? 16'hffff : 16'($urandom)));
      // each column with its own frac_y
      send_column(pack_column(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h5555));
      send_column(pack_column(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0001, 16'haaaa));
      send_column(pack_column(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'h0000));
      send_column(pack_column(16'h0001, 16'hffff, 16'h4000, 16'hc000, 16'h4000, 16'h0001));
   endtask

   initial begin
      pixels = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 52;
      send_directed();
      for (int g = 0; g < 78; g++) send_random_group();
      drain_pixels();

      send_idle_pct = 52;
      recv_idle_pct = 32;
      for (int g = 0; g < 78; g++) send_random_group();
      drain_pixels();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int g = 0; g < 76; g++) send_random_group();
      drain_pixels();

      // nothing should follow the last pixel
      repeat (40) @(posedge clock);
      if (pixels.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/bcr_pkg.sv
src/bcr_front.sv
src/bcr_queue.sv
src/bcr_back.sv
src/bicubic_catmull_rom_kernel_core.sv
test/bicubic_catmull_rom_kernel_core_tb.sv
